@@ design/nhvv_pkg.sv @@
`default_nettype none
package nhvv_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_BITS  = 31;

    typedef logic signed [WORD_BITS-1:0] word_t;
    // operand of the shared unit: one bit wider so 2^31 fits as a multiplier
    typedef logic signed [WORD_BITS:0]   oprd_t;

    localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam int          Q32_SHIFT = 32 - FRAC_BITS;

    localparam oprd_t ONE_Q   = oprd_t'(64'd1 << FRAC_BITS);
    localparam oprd_t LOG2E_Q = oprd_t'((LOG2E_Q32 + (64'd1 << (Q32_SHIFT - 1))) >> Q32_SHIFT);
    localparam oprd_t LN2_Q   = oprd_t'((LN2_Q32 + (64'd1 << (Q32_SHIFT - 1))) >> Q32_SHIFT);

    localparam logic [5:0] SH_Q     = 6'(FRAC_BITS);
    localparam logic [5:0] SH_HALF  = 6'(FRAC_BITS + 1);
    localparam logic [5:0] SH_RECIP = 6'd31;

    localparam logic [CFG_BITS-1:0] DT_RESET  = CFG_BITS'(327);
    localparam logic [CFG_BITS-1:0] TAU_RESET = CFG_BITS'(65536);
    localparam logic [CFG_BITS-1:0] TGT_RESET = CFG_BITS'(65536);

    localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [1:0] CFG_TAU         = 2'd1;
    localparam logic [1:0] CFG_TARGET_TEMP = 2'd2;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_THERMO = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        word_t               vel_x;
        word_t               vel_y;
        word_t               vel_z;
        word_t               vec_x;
        word_t               vec_y;
        word_t               vec_z;
        word_t               pos_x;
        word_t               pos_y;
        word_t               pos_z;
        logic [CFG_BITS-1:0] mass;
        logic [CFG_BITS-1:0] measured_temperature;
    } nhvv_in_t;

    typedef struct packed {
        word_t new_vel_x;
        word_t new_vel_y;
        word_t new_vel_z;
        word_t new_pos_x;
        word_t new_pos_y;
        word_t new_pos_z;
        word_t new_accel_x;
        word_t new_accel_y;
        word_t new_accel_z;
        word_t friction_out;
        word_t bath_position_out;
        logic  saturated;
    } nhvv_out_t;

    typedef struct packed {
        logic       go;
        logic       mul;
        logic       sub;
        logic [5:0] sh;
        logic       rnd;
        oprd_t      a;
        oprd_t      b;
    } alu_req_t;

    typedef struct packed {
        logic                go;
        oprd_t               num;
        logic [CFG_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t res;
        logic  sat;
    } unit_rsp_t;

    // ceil(2^31 / k): floor(x / k) = (x * m) >> 31 for the small series terms
    function automatic oprd_t recip_k(input logic [2:0] k);
        oprd_t m;
        unique case (k)
            3'd1:    m = oprd_t'(64'd2147483648);
            3'd2:    m = oprd_t'(64'd1073741824);
            3'd3:    m = oprd_t'(64'd715827883);
            3'd4:    m = oprd_t'(64'd536870912);
            3'd5:    m = oprd_t'(64'd429496730);
            3'd6:    m = oprd_t'(64'd357913942);
            3'd7:    m = oprd_t'(64'd306783379);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ design/nhvv_alu.sv @@
`default_nettype none
module nhvv_alu
    import nhvv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire alu_req_t  req,
    output unit_rsp_t      rsp
);

    localparam int OW = WORD_BITS + 1;
    localparam int SW = WORD_BITS + 3;
    localparam int PW = 2 * OW;
    localparam logic [PW-1:0] MAG_MAX = PW'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [PW-1:0] MAG_NEG = MAG_MAX + PW'(1);

    logic [OW-1:0]        a_mag;
    logic [OW-1:0]        b_mag;
    logic signed [SW-1:0] sum;
    logic [SW-1:0]        sum_mag;
    logic [PW-1:0]        mag_next;
    logic                 neg_next;
    logic [PW-1:0]        mag_reg;
    logic                 neg_reg;
    logic [5:0]           sh_reg;
    logic                 rnd_reg;
    logic                 v_reg;
    logic [PW-1:0]        half;
    logic [PW-1:0]        rounded;

    always_comb
    begin
        a_mag   = req.a[WORD_BITS] ? OW'(-req.a) : OW'(req.a);
        b_mag   = req.b[WORD_BITS] ? OW'(-req.b) : OW'(req.b);
        sum     = SW'(req.a) + (req.sub ? -SW'(req.b) : SW'(req.b));
        sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
        if (req.mul)
        begin
            mag_next = PW'(a_mag) * PW'(b_mag);
            neg_next = req.a[WORD_BITS] ^ req.b[WORD_BITS];
        end
        else
        begin
            mag_next = PW'(sum_mag);
            neg_next = sum[SW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= req.go;
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            sh_reg  <= req.sh;
            rnd_reg <= req.rnd;
        end
    end

    // second half: shift, round half away from zero if rnd, saturate
    always_comb
    begin
        half    = rnd_reg ? (PW'(1) << (sh_reg - 6'd1)) : '0;
        rounded = (mag_reg + half) >> sh_reg;
        rsp.done = v_reg;
        rsp.sat  = 1'b0;
        if (neg_reg)
        begin
            if (rounded > MAG_NEG)
            begin
                rsp.res = word_t'(MAG_NEG[WORD_BITS-1:0]);
                rsp.sat = 1'b1;
            end
            else
                rsp.res = -word_t'(rounded[WORD_BITS-1:0]);
        end
        else
        begin
            if (rounded > MAG_MAX)
            begin
                rsp.res = word_t'(MAG_MAX[WORD_BITS-1:0]);
                rsp.sat = 1'b1;
            end
            else
                rsp.res = word_t'(rounded[WORD_BITS-1:0]);
        end
    end

endmodule
`default_nettype wire

@@ design/nhvv_div.sv @@
`default_nettype none
module nhvv_div
    import nhvv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_req_t  req,
    output unit_rsp_t      rsp
);

    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [NB:0] Q_MAX = (NB+1)'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [NB:0] Q_NEG = Q_MAX + (NB+1)'(1);

    logic                busy_reg;
    logic                fin_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [NB-1:0]       n_reg;
    logic [NB-1:0]       q_reg;
    logic [CFG_BITS-1:0] r_reg;
    logic [CFG_BITS-1:0] d_reg;
    logic                neg_reg;
    word_t               res_reg;
    logic                sat_reg;
    logic [WORD_BITS:0]  num_mag;
    logic [CFG_BITS:0]   trial;
    logic                fits;
    logic                round_up;
    logic [NB:0]         q_round;

    always_comb
    begin
        num_mag  = req.num[WORD_BITS] ? (WORD_BITS+1)'(-req.num) : (WORD_BITS+1)'(req.num);
        trial    = {r_reg, n_reg[NB-1]};
        fits     = trial >= {1'b0, d_reg};
        round_up = {r_reg, 1'b0} >= {1'b0, d_reg};
        q_round  = (NB+1)'(q_reg) + (NB+1)'(round_up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NB - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            n_reg   <= {num_mag[WORD_BITS-1:0], {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            r_reg   <= '0;
            d_reg   <= req.den;
            neg_reg <= req.num[WORD_BITS];
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[NB-2:0], 1'b0};
            q_reg <= {q_reg[NB-2:0], fits};
            r_reg <= fits ? CFG_BITS'(trial - {1'b0, d_reg}) : CFG_BITS'(trial);
        end
        if (fin_reg)
        begin
            sat_reg <= 1'b0;
            if (neg_reg)
            begin
                if (q_round > Q_NEG)
                begin
                    res_reg <= word_t'(Q_NEG[WORD_BITS-1:0]);
                    sat_reg <= 1'b1;
                end
                else
                    res_reg <= -word_t'(q_round[WORD_BITS-1:0]);
            end
            else
            begin
                if (q_round > Q_MAX)
                begin
                    res_reg <= word_t'(Q_MAX[WORD_BITS-1:0]);
                    sat_reg <= 1'b1;
                end
                else
                    res_reg <= word_t'(q_round[WORD_BITS-1:0]);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
    assign rsp.sat  = sat_reg;

endmodule
`default_nettype wire

@@ design/nose_hoover_velocity_verlet_step_unit.sv @@
// Nose-Hoover velocity-Verlet step engine, signed Q16.16 words.
// Requests arrive on in_valid/in_ready with one nhvv_in_t; each gives exactly
// one nhvv_out_t on out_valid/out_ready. Registers (time step, tau, target
// temperature) are written on cfg_valid/cfg_ready, always ready; the user
// must write them only while idle, the block itself does not enforce it.
// One request at a time: in_ready is high only while the sequencer is idle.
// All arithmetic goes through one shared multiply/add unit and one restoring
// divider (one quotient bit a cycle). Work per request kind after acceptance:
//   kind 0 (first half step)  : 15 ops
//   kind 1 (second half step) : 3 divides, 9 ops
//   kind 2 (thermostat)       : 3 divides, 38 ops, 1 shift
//   kind 3                    : no ops, all-zero result
// A finished result sits in the output register; the next request is taken
// while it waits, and a new result is held back only while the old one stalls.
// Reset loads the register defaults and sets friction and bath position to
// zero and the scale factor to 1.0.
`default_nettype none
module nose_hoover_velocity_verlet_step_unit
    import nhvv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire nhvv_in_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output nhvv_out_t                out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_EXPSH = 5'b01000,
        ST_FIN   = 5'b10000
    } st_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ONE, SRC_DT, SRC_SF, SRC_VEL, SRC_VEC, SRC_POS, SRC_TMP,
        SRC_NVEL, SRC_NACC, SRC_XI, SRC_ETA, SRC_MID, SRC_COEF, SRC_KICK,
        SRC_TERM, SRC_G, SRC_SUM, SRC_KHALF, SRC_RECIP, SRC_LOG2E, SRC_LN2,
        SRC_FRAC, SRC_MEAS
    } src_t;

    typedef enum logic [1:0] {
        DV_MASS, DV_TAU, DV_TGT
    } dvs_t;

    typedef enum logic [3:0] {
        DST_TMP, DST_NVEL, DST_NPOS, DST_NACC, DST_XI, DST_ETA, DST_MID,
        DST_COEF, DST_KICK, DST_TERM, DST_G, DST_SUM
    } dst_t;

    typedef struct packed {
        logic       is_div;
        logic       is_mul;
        logic       sub;
        logic [5:0] sh;
        logic       rnd;
        src_t       asel;
        src_t       bsel;
        dvs_t       dvs;
        dst_t       dst;
        logic       last;
    } uop_t;

    localparam logic [4:0] STP_G    = 5'd12;
    localparam logic [4:0] STP_TERM = 5'd13;
    localparam logic [4:0] STP_SUM  = 5'd16;
    localparam logic [2:0] K_LAST   = 3'd7;
    localparam logic [1:0] AX_LAST  = 2'd2;
    localparam int         NW       = WORD_BITS - FRAC_BITS;
    localparam logic [63:0] WMAX64  = 64'({1'b0, {(WORD_BITS-1){1'b1}}});

    function automatic uop_t op_mul(input src_t a, input src_t b, input logic [5:0] sh,
                                    input logic rnd, input dst_t d);
        uop_t u;
        u = '{is_div: 1'b0, is_mul: 1'b1, sub: 1'b0, sh: sh, rnd: rnd, asel: a,
              bsel: b, dvs: DV_MASS, dst: d, last: 1'b0};
        return u;
    endfunction

    function automatic uop_t op_add(input src_t a, input src_t b, input logic sub,
                                    input dst_t d, input logic last);
        uop_t u;
        u = '{is_div: 1'b0, is_mul: 1'b0, sub: sub, sh: 6'd0, rnd: 1'b0, asel: a,
              bsel: b, dvs: DV_MASS, dst: d, last: last};
        return u;
    endfunction

    function automatic uop_t op_div(input src_t a, input dvs_t v, input dst_t d);
        uop_t u;
        u = '{is_div: 1'b1, is_mul: 1'b0, sub: 1'b0, sh: 6'd0, rnd: 1'b0, asel: a,
              bsel: SRC_ZERO, dvs: v, dst: d, last: 1'b0};
        return u;
    endfunction

    function automatic logic [CFG_BITS-1:0] nonzero(input logic [CFG_BITS-1:0] v);
        return (v == '0) ? CFG_BITS'(1) : v;
    endfunction

    st_t                 state_reg;
    nhvv_in_t            in_reg;
    logic [CFG_BITS-1:0] dt_reg;
    logic [CFG_BITS-1:0] tau_reg;
    logic [CFG_BITS-1:0] tgt_reg;
    word_t               xi_reg;
    word_t               eta_reg;
    word_t               sf_reg;
    word_t               tmp_reg;
    word_t               mid_reg;
    word_t               coef_reg;
    word_t               kick_reg;
    word_t               term_reg;
    word_t               g_reg;
    word_t               sum_reg;
    word_t               nvel_reg [3];
    word_t               npos_reg [3];
    word_t               nacc_reg [3];
    logic [4:0]          step_reg;
    logic [1:0]          axis_reg;
    logic [2:0]          k_reg;
    logic                sat_reg;
    logic                out_valid_reg;
    nhvv_out_t           out_reg;
    nhvv_out_t           out_next;

    uop_t                uop;
    alu_req_t            alu_req;
    div_req_t            div_req;
    unit_rsp_t           alu_rsp;
    unit_rsp_t           div_rsp;
    logic                unit_done;
    logic                wb_en;
    word_t               wb_val;
    logic                wb_sat;
    word_t               vel_sel;
    word_t               vec_sel;
    word_t               pos_sel;
    oprd_t               opa;
    oprd_t               opb;
    logic [CFG_BITS-1:0] den_sel;
    logic signed [NW-1:0] exp_n;
    logic [NW-1:0]       exp_m;
    logic [63:0]         exp_shl;
    logic [63:0]         exp_shr;
    word_t               exp_val;
    logic                exp_sat;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                vel_sel = in_reg.vel_x;
                vec_sel = in_reg.vec_x;
                pos_sel = in_reg.pos_x;
            end
            2'd1:
            begin
                vel_sel = in_reg.vel_y;
                vec_sel = in_reg.vec_y;
                pos_sel = in_reg.pos_y;
            end
            default:
            begin
                vel_sel = in_reg.vel_z;
                vec_sel = in_reg.vec_z;
                pos_sel = in_reg.pos_z;
            end
        endcase
    end

    // microcode: per kind, a short program indexed by step
    always_comb
    begin
        uop = op_add(SRC_ZERO, SRC_ZERO, 1'b0, DST_TMP, 1'b1);
        unique case (in_reg.kind)
            KIND_FIRST:
            begin
                unique case (step_reg)
                    5'd0:    uop = op_mul(SRC_VEC, SRC_DT, SH_HALF, 1'b1, DST_TMP);
                    5'd1:    uop = op_add(SRC_VEL, SRC_TMP, 1'b0, DST_NVEL, 1'b0);
                    5'd2:    uop = op_mul(SRC_NVEL, SRC_SF, SH_Q, 1'b1, DST_NVEL);
                    5'd3:    uop = op_mul(SRC_DT, SRC_NVEL, SH_Q, 1'b1, DST_TMP);
                    default: uop = op_add(SRC_POS, SRC_TMP, 1'b0, DST_NPOS, 1'b1);
                endcase
            end
            KIND_SECOND:
            begin
                unique case (step_reg)
                    5'd0:    uop = op_div(SRC_VEC, DV_MASS, DST_NACC);
                    5'd1:    uop = op_mul(SRC_VEL, SRC_SF, SH_Q, 1'b1, DST_NVEL);
                    5'd2:    uop = op_mul(SRC_DT, SRC_NACC, SH_HALF, 1'b1, DST_TMP);
                    default: uop = op_add(SRC_NVEL, SRC_TMP, 1'b0, DST_NVEL, 1'b1);
                endcase
            end
            KIND_THERMO:
            begin
                unique case (step_reg)
                    5'd0:    uop = op_div(SRC_DT, DV_TAU, DST_TMP);
                    5'd1:    uop = op_div(SRC_TMP, DV_TAU, DST_COEF);
                    5'd2:    uop = op_div(SRC_MEAS, DV_TGT, DST_TMP);
                    5'd3:    uop = op_add(SRC_TMP, SRC_ONE, 1'b1, DST_TMP, 1'b0);
                    5'd4:    uop = op_mul(SRC_COEF, SRC_TMP, SH_HALF, 1'b1, DST_KICK);
                    5'd5:    uop = op_add(SRC_XI, SRC_KICK, 1'b0, DST_MID, 1'b0);
                    5'd6:    uop = op_add(SRC_MID, SRC_KICK, 1'b0, DST_XI, 1'b0);
                    5'd7:    uop = op_mul(SRC_MID, SRC_DT, SH_Q, 1'b1, DST_TMP);
                    5'd8:    uop = op_add(SRC_ETA, SRC_TMP, 1'b0, DST_ETA, 1'b0);
                    5'd9:    uop = op_mul(SRC_XI, SRC_DT, SH_HALF, 1'b1, DST_TMP);
                    5'd10:   uop = op_add(SRC_ZERO, SRC_TMP, 1'b1, DST_TMP, 1'b0);
                    5'd11:   uop = op_mul(SRC_TMP, SRC_LOG2E, SH_Q, 1'b1, DST_TMP);
                    5'd12:   uop = op_mul(SRC_FRAC, SRC_LN2, SH_Q, 1'b1, DST_G);
                    5'd13:   uop = op_mul(SRC_TERM, SRC_G, SH_Q, 1'b1, DST_TERM);
                    5'd14:   uop = op_add(SRC_TERM, SRC_KHALF, 1'b0, DST_TERM, 1'b0);
                    5'd15:   uop = op_mul(SRC_TERM, SRC_RECIP, SH_RECIP, 1'b0, DST_TERM);
                    default: uop = op_add(SRC_SUM, SRC_TERM, 1'b0, DST_SUM, 1'b0);
                endcase
            end
            default: ;
        endcase
    end

    function automatic oprd_t src_val(input src_t s);
        oprd_t v;
        unique case (s)
            SRC_ZERO:  v = '0;
            SRC_ONE:   v = ONE_Q;
            SRC_DT:    v = oprd_t'({2'b00, dt_reg});
            SRC_SF:    v = oprd_t'(sf_reg);
            SRC_VEL:   v = oprd_t'(vel_sel);
            SRC_VEC:   v = oprd_t'(vec_sel);
            SRC_POS:   v = oprd_t'(pos_sel);
            SRC_TMP:   v = oprd_t'(tmp_reg);
            SRC_NVEL:  v = oprd_t'(nvel_reg[axis_reg]);
            SRC_NACC:  v = oprd_t'(nacc_reg[axis_reg]);
            SRC_XI:    v = oprd_t'(xi_reg);
            SRC_ETA:   v = oprd_t'(eta_reg);
            SRC_MID:   v = oprd_t'(mid_reg);
            SRC_COEF:  v = oprd_t'(coef_reg);
            SRC_KICK:  v = oprd_t'(kick_reg);
            SRC_TERM:  v = oprd_t'(term_reg);
            SRC_G:     v = oprd_t'(g_reg);
            SRC_SUM:   v = oprd_t'(sum_reg);
            SRC_KHALF: v = oprd_t'({1'b0, k_reg[2:1]});
            SRC_RECIP: v = recip_k(k_reg);
            SRC_LOG2E: v = LOG2E_Q;
            SRC_LN2:   v = LN2_Q;
            SRC_FRAC:  v = oprd_t'({1'b0, tmp_reg[FRAC_BITS-1:0]});
            SRC_MEAS:  v = oprd_t'({2'b00, in_reg.measured_temperature});
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = src_val(uop.asel);
        opb = src_val(uop.bsel);
        unique case (uop.dvs)
            DV_MASS: den_sel = nonzero(in_reg.mass);
            DV_TAU:  den_sel = nonzero(tau_reg);
            DV_TGT:  den_sel = nonzero(tgt_reg);
            default: den_sel = CFG_BITS'(1);
        endcase
        alu_req = '{go: (state_reg == ST_ISSUE) && !uop.is_div, mul: uop.is_mul,
                    sub: uop.sub, sh: uop.sh, rnd: uop.rnd, a: opa, b: opb};
        div_req = '{go: (state_reg == ST_ISSUE) && uop.is_div, num: opa, den: den_sel};
        unit_done = uop.is_div ? div_rsp.done : alu_rsp.done;
        wb_val    = uop.is_div ? div_rsp.res : alu_rsp.res;
        wb_sat    = uop.is_div ? div_rsp.sat : alu_rsp.sat;
        wb_en     = (state_reg == ST_WAIT) && unit_done;
    end

    nhvv_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    nhvv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // 2^n scaling of the series sum, n taken from the integer part of tmp
    always_comb
    begin
        exp_n   = tmp_reg[WORD_BITS-1:FRAC_BITS];
        exp_m   = NW'(-exp_n);
        exp_shl = {{(64-WORD_BITS){1'b0}}, sum_reg} << exp_n[4:0];
        exp_shr = ({{(64-WORD_BITS){1'b0}}, sum_reg} + (64'd1 << (exp_m[4:0] - 5'd1)))
                  >> exp_m[4:0];
        exp_sat = 1'b0;
        if (!exp_n[NW-1])
        begin
            if (exp_n > NW'(NW) || exp_shl > WMAX64)
            begin
                exp_val = word_t'(WMAX64[WORD_BITS-1:0]);
                exp_sat = 1'b1;
            end
            else
                exp_val = word_t'(exp_shl[WORD_BITS-1:0]);
        end
        else if (exp_m >= NW'(32))
            exp_val = '0;
        else
            exp_val = word_t'(exp_shr[WORD_BITS-1:0]);
    end

    always_comb
    begin
        out_next.new_vel_x         = nvel_reg[0];
        out_next.new_vel_y         = nvel_reg[1];
        out_next.new_vel_z         = nvel_reg[2];
        out_next.new_pos_x         = npos_reg[0];
        out_next.new_pos_y         = npos_reg[1];
        out_next.new_pos_z         = npos_reg[2];
        out_next.new_accel_x       = nacc_reg[0];
        out_next.new_accel_y       = nacc_reg[1];
        out_next.new_accel_z       = nacc_reg[2];
        out_next.friction_out      = (in_reg.kind == KIND_THERMO) ? xi_reg : '0;
        out_next.bath_position_out = (in_reg.kind == KIND_THERMO) ? eta_reg : '0;
        out_next.saturated         = sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            k_reg         <= 3'd1;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            dt_reg        <= DT_RESET;
            tau_reg       <= TAU_RESET;
            tgt_reg       <= TGT_RESET;
            xi_reg        <= '0;
            eta_reg       <= '0;
            sf_reg        <= word_t'(ONE_Q);
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TIME_STEP:   dt_reg  <= cfg_data;
                    CFG_TAU:         tau_reg <= cfg_data;
                    CFG_TARGET_TEMP: tgt_reg <= cfg_data;
                    default: ;
                endcase
            end
            // in the finish state the hand-over below decides the flag
            if (out_valid_reg && out_ready && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sat_reg   <= 1'b0;
                        step_reg  <= '0;
                        axis_reg  <= '0;
                        state_reg <= (in_data.kind == KIND_FIRST ||
                                      in_data.kind == KIND_SECOND ||
                                      in_data.kind == KIND_THERMO) ? ST_ISSUE : ST_FIN;
                    end
                end
                ST_ISSUE:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (wb_en)
                    begin
                        sat_reg <= sat_reg | wb_sat;
                        if (uop.dst == DST_XI)
                            xi_reg <= wb_val;
                        if (uop.dst == DST_ETA)
                            eta_reg <= wb_val;
                        if (in_reg.kind == KIND_THERMO && step_reg == STP_G)
                            k_reg <= 3'd1;
                        // series loop of the exponential
                        if (in_reg.kind == KIND_THERMO && step_reg == STP_SUM)
                        begin
                            if (k_reg == K_LAST)
                                state_reg <= ST_EXPSH;
                            else
                            begin
                                k_reg     <= k_reg + 3'd1;
                                step_reg  <= STP_TERM;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        else if (uop.last)
                        begin
                            if (axis_reg == AX_LAST)
                                state_reg <= ST_FIN;
                            else
                            begin
                                axis_reg  <= axis_reg + 2'd1;
                                step_reg  <= '0;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        else
                        begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_EXPSH:
                begin
                    sf_reg    <= exp_val;
                    sat_reg   <= sat_reg | exp_sat;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            in_reg <= in_data;
            for (int i = 0; i < 3; i++)
            begin
                nvel_reg[i] <= '0;
                npos_reg[i] <= '0;
                nacc_reg[i] <= '0;
            end
        end
        if (wb_en)
        begin
            unique case (uop.dst)
                DST_TMP:  tmp_reg            <= wb_val;
                DST_NVEL: nvel_reg[axis_reg] <= wb_val;
                DST_NPOS: npos_reg[axis_reg] <= wb_val;
                DST_NACC: nacc_reg[axis_reg] <= wb_val;
                DST_MID:  mid_reg            <= wb_val;
                DST_COEF: coef_reg           <= wb_val;
                DST_KICK: kick_reg           <= wb_val;
                DST_TERM: term_reg           <= wb_val;
                DST_G:    g_reg              <= wb_val;
                DST_SUM:  sum_reg            <= wb_val;
                default: ;
            endcase
            if (in_reg.kind == KIND_THERMO && step_reg == STP_G)
            begin
                term_reg <= word_t'(ONE_Q);
                sum_reg  <= word_t'(ONE_Q);
            end
        end
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            out_reg <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

@@ design/nhvv_chk.sv @@
`default_nettype none
module nhvv_chk
    import nhvv_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire nhvv_out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a new result only follows a busy sequencer
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without work");

    // particle step and thermostat results never mix
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.new_pos_x != 0 || out_data.new_accel_x != 0)
        |-> out_data.friction_out == 0 && out_data.bath_position_out == 0 &&
            (out_data.new_pos_x == 0 || out_data.new_accel_x == 0))
        else $error("mixed result fields");

endmodule

bind nose_hoover_velocity_verlet_step_unit nhvv_chk u_nhvv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

@@ sim/nose_hoover_velocity_verlet_step_unit_test.sv @@
`timescale 1ns / 100ps

module nose_hoover_velocity_verlet_step_unit_test;
    import nhvv_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam longint Q_ONE = 64'sd65536;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    nhvv_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    nhvv_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    nose_hoover_velocity_verlet_step_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of registers and thermostat state
    logic [CFG_BITS-1:0] dt_reg = DT_RESET;
    logic [CFG_BITS-1:0] tau_reg = TAU_RESET;
    logic [CFG_BITS-1:0] tgt_reg = TGT_RESET;
    longint friction_q = 0;
    longint bath_q = 0;
    longint scale_q = Q_ONE;
    bit clamp_hit;

    nhvv_in_t pending_requests[$];
    nhvv_out_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int kind_count[4] = '{0, 0, 0, 0};
    int sat_count = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic longint clampw(longint v);
        if (v > W_MAX)
        begin
            clamp_hit = 1'b1;
            return W_MAX;
        end
        if (v < W_MIN)
        begin
            clamp_hit = 1'b1;
            return W_MIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] mag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint from_mag(bit neg, logic [127:0] m);
        if (neg)
        begin
            if (m > 128'd2147483648)
            begin
                clamp_hit = 1'b1;
                return W_MIN;
            end
            return -longint'(m[63:0]);
        end
        if (m > 128'd2147483647)
        begin
            clamp_hit = 1'b1;
            return W_MAX;
        end
        return longint'(m[63:0]);
    endfunction

    // round(a*b / 2^s), ties away from zero
    function automatic longint mul_round(longint a, longint b, int s);
        logic [127:0] p;
        p = 128'(mag(a)) * 128'(mag(b));
        p = (p + (128'd1 << (s - 1))) >> s;
        return from_mag((a < 0) != (b < 0), p);
    endfunction

    // round(a*2^16 / d)
    function automatic longint div_round(longint a, logic [63:0] d);
        logic [127:0] p, q, r;
        p = 128'(mag(a)) << FRAC_BITS;
        q = p / 128'(d);
        r = p % 128'(d);
        if (r >= 128'(d) - r)
            q = q + 1;
        return from_mag(a < 0, q);
    endfunction

    function automatic logic [63:0] nonzero(logic [CFG_BITS-1:0] u);
        return u == 0 ? 64'd1 : 64'(u);
    endfunction

    // exp(-x) by range reduction and a series up to the seventh power
    function automatic longint exp_decay(longint x);
        longint y, t, f, n, g, total, term;
        int sh;
        y = clampw(-x);
        t = mul_round(y, longint'(LOG2E_Q), FRAC_BITS);
        f = t & (Q_ONE - 1);
        n = (t - f) / Q_ONE;
        g = mul_round(f, longint'(LN2_Q), FRAC_BITS);
        total = Q_ONE;
        term = Q_ONE;
        for (int k = 1; k <= 7; k++)
        begin
            term = mul_round(term, g, FRAC_BITS);
            term = (term + k / 2) / k;
            total += term;
        end
        if (n >= 0)
        begin
            if (n >= 62 || total > (W_MAX >>> n))
            begin
                clamp_hit = 1'b1;
                return W_MAX;
            end
            return clampw(total <<< n);
        end
        if (-n >= 63)
            return 0;
        sh = int'(-n);
        return longint'((64'(total) + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic nhvv_out_t advance_particle(nhvv_in_t it);
        nhvv_out_t o;
        longint vel[3], vec[3], pos[3], nv[3], np[3], na[3];
        longint dt, v, a, coef, err, kick, mid, meas;
        logic [63:0] m, tau, tgt;
        clamp_hit = 1'b0;
        vel = '{it.vel_x, it.vel_y, it.vel_z};
        vec = '{it.vec_x, it.vec_y, it.vec_z};
        pos = '{it.pos_x, it.pos_y, it.pos_z};
        nv = '{0, 0, 0};
        np = '{0, 0, 0};
        na = '{0, 0, 0};
        dt = longint'(dt_reg);
        o = '0;
        if (it.kind == KIND_FIRST)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v = clampw(vel[i] + mul_round(vec[i], dt, FRAC_BITS + 1));
                v = mul_round(v, scale_q, FRAC_BITS);
                nv[i] = v;
                np[i] = clampw(pos[i] + mul_round(dt, v, FRAC_BITS));
            end
        end
        else if (it.kind == KIND_SECOND)
        begin
            m = nonzero(it.mass);
            for (int i = 0; i < 3; i++)
            begin
                a = div_round(vec[i], m);
                v = mul_round(vel[i], scale_q, FRAC_BITS);
                nv[i] = clampw(v + mul_round(dt, a, FRAC_BITS + 1));
                na[i] = a;
            end
        end
        else if (it.kind == KIND_THERMO)
        begin
            tau = nonzero(tau_reg);
            tgt = nonzero(tgt_reg);
            meas = longint'(it.measured_temperature);
            coef = div_round(div_round(dt, tau), tau);
            err = clampw(div_round(meas, tgt) - Q_ONE);
            kick = mul_round(coef, err, FRAC_BITS + 1);
            mid = clampw(friction_q + kick);
            friction_q = clampw(mid + kick);
            bath_q = clampw(bath_q + mul_round(mid, dt, FRAC_BITS));
            scale_q = exp_decay(mul_round(friction_q, dt, FRAC_BITS + 1));
            o.friction_out = word_t'(friction_q);
            o.bath_position_out = word_t'(bath_q);
        end
        o.new_vel_x = word_t'(nv[0]);
        o.new_vel_y = word_t'(nv[1]);
        o.new_vel_z = word_t'(nv[2]);
        o.new_pos_x = word_t'(np[0]);
        o.new_pos_y = word_t'(np[1]);
        o.new_pos_z = word_t'(np[2]);
        o.new_accel_x = word_t'(na[0]);
        o.new_accel_y = word_t'(na[1]);
        o.new_accel_z = word_t'(na[2]);
        o.saturated = clamp_hit;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 60)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return word_t'(W_MAX);
            1: return word_t'(W_MIN);
            2, 3, 4, 5: return word_t'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: return CFG_BITS'($urandom_range(1, 1 << 20));
            default: return CFG_BITS'($urandom);
        endcase
    endfunction

    function automatic nhvv_in_t rand_request();
        nhvv_in_t it;
        int r;
        r = $urandom_range(0, 99);
        it.kind = r < 40 ? KIND_FIRST : r < 70 ? KIND_SECOND : r < 95 ? KIND_THERMO : KIND_SPARE;
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        it.vec_x = rand_word();
        it.vec_y = rand_word();
        it.vec_z = rand_word();
        it.pos_x = rand_word();
        it.pos_y = rand_word();
        it.pos_z = rand_word();
        it.mass = rand_pos();
        // mostly near the set point so the thermostat stays in range
        if ($urandom_range(0, 3) != 0)
            it.measured_temperature = CFG_BITS'(longint'(tgt_reg)
                + longint'($urandom_range(0, 4096)) - 2048);
        else
            it.measured_temperature = rand_pos();
        return it;
    endfunction

    task automatic check_word(string name, word_t want, word_t got);
        if (got !== want)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(advance_particle(in_data));
                kind_count[in_data.kind]++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_data <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once the run is under way
    always @(posedge clk)
    begin
        if (!hold_done && results_seen >= 300)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        nhvv_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_word("new_vel_x", want.new_vel_x, out_data.new_vel_x);
                    check_word("new_vel_y", want.new_vel_y, out_data.new_vel_y);
                    check_word("new_vel_z", want.new_vel_z, out_data.new_vel_z);
                    check_word("new_pos_x", want.new_pos_x, out_data.new_pos_x);
                    check_word("new_pos_y", want.new_pos_y, out_data.new_pos_y);
                    check_word("new_pos_z", want.new_pos_z, out_data.new_pos_z);
                    check_word("new_accel_x", want.new_accel_x, out_data.new_accel_x);
                    check_word("new_accel_y", want.new_accel_y, out_data.new_accel_y);
                    check_word("new_accel_z", want.new_accel_z, out_data.new_accel_z);
                    check_word("friction_out", want.friction_out, out_data.friction_out);
                    check_word("bath_position_out", want.bath_position_out,
                               out_data.bath_position_out);
                    if (out_data.saturated !== want.saturated)
                    begin
                        $error("saturated expected %0d actual %0d",
                               want.saturated, out_data.saturated);
                        errors++;
                    end
                    if (want.saturated)
                        sat_count++;
                end
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TIME_STEP)
            dt_reg = value;
        else if (idx == CFG_TAU)
            tau_reg = value;
        else
            tgt_reg = value;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic push_directed(logic [1:0] kind, word_t v, word_t a, word_t p,
                                 logic [CFG_BITS-1:0] m, logic [CFG_BITS-1:0] t);
        nhvv_in_t it;
        it = '{kind, v, v, v, a, a, a, p, p, p, m, t};
        pending_requests.push_back(it);
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] set_dt, set_tau, set_tgt;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes, every kind, zero mass and zero temperature
        push_directed(KIND_FIRST, '0, '0, '0, '0, '0);
        push_directed(KIND_FIRST, word_t'(W_MAX), word_t'(W_MAX), word_t'(W_MAX), '1, '1);
        push_directed(KIND_FIRST, word_t'(W_MIN), word_t'(W_MIN), word_t'(W_MIN), '0, '0);
        push_directed(KIND_SECOND, 32'sd65536, 32'sd65536, '0, '0, '0);
        push_directed(KIND_SECOND, '0, word_t'(W_MAX), '0, 31'd1, '0);
        push_directed(KIND_SECOND, word_t'(W_MIN), word_t'(W_MIN), '0, '1, '0);
        push_directed(KIND_SECOND, word_t'(W_MAX), word_t'(W_MIN), '0, 31'd1, '0);
        push_directed(KIND_THERMO, '0, '0, '0, '0, '0);
        push_directed(KIND_THERMO, '0, '0, '0, '0, 31'd65536);
        push_directed(KIND_THERMO, '0, '0, '0, '0, '1);
        push_directed(KIND_FIRST, 32'sd100000, -32'sd70000, 32'sd5, '0, '0);
        push_directed(KIND_SECOND, -32'sd100000, 32'sd70000, '0, 31'd131072, '0);
        push_directed(KIND_SPARE, word_t'($urandom), word_t'($urandom), word_t'($urandom),
                      '1, '1);
        push_directed(KIND_THERMO, '0, '0, '0, '0, 31'd32768);
        for (int i = 0; i < 6; i++)
            pending_requests.push_back(rand_request());

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                case (phase)
                    1: begin set_dt = '1; set_tau = '1; set_tgt = '1; end
                    2: begin set_dt = '0; set_tau = '0; set_tgt = '0; end
                    3: begin set_dt = 31'd1; set_tau = 31'd1; set_tgt = 31'd1; end
                    default:
                    begin
                        set_dt = CFG_BITS'($urandom_range(1, 8192));
                        set_tau = CFG_BITS'($urandom_range(16384, 1 << 18));
                        set_tgt = CFG_BITS'($urandom_range(1, 1 << 24));
                    end
                endcase
                write_reg(CFG_TIME_STEP, set_dt);
                write_reg(CFG_TAU, set_tau);
                write_reg(CFG_TARGET_TEMP, set_tgt);
            end
            quiet = (phase == 5);
            for (int i = 0; i < 175; i++)
                pending_requests.push_back(rand_request());
        end

        wait_idle();
        repeat (300) @(posedge clk);
        $display("checked %0d results: %0d first half, %0d second half, %0d thermostat,",
                 results_seen, kind_count[0], kind_count[1], kind_count[2]);
        $display("%0d spare-kind requests, %0d saturated results, 8 register settings",
                 kind_count[3], sat_count);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
